### design/fluc_pkg.sv
// ----------------------------------------------------------------------------
// fluc_pkg: shared types and constants of the fixed-length code unpacker
// Word formats, default sizes and the entry carried from front to back.
// ----------------------------------------------------------------------------
package fluc_pkg;

   localparam int DICT_DEPTH_DEF    = 256;
   localparam int MAX_CODE_BITS_DEF = 8;

   localparam int BYTE_W  = 8;   // compressed byte
   localparam int SYM_W   = 8;   // symbol
   localparam int IDX_W   = 8;   // dictionary index field
   localparam int CNT_W   = 4;   // bit count 0..8
   localparam int CSR_W   = 4;   // code_length register
   localparam int Q_DEPTH = 2;

   localparam logic [CSR_W-1:0]  CODE_LEN_RESET = 4'd8;
   localparam logic [CNT_W-1:0]  BYTE_BITS      = 4'd8;
   localparam logic [BYTE_W-1:0] HDR_CLEAR      = 8'hf8;

   // req_type codes
   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_DATA = 1'b1;

   typedef struct packed {
      logic              is_load;
      logic [IDX_W-1:0]  index;
      logic [SYM_W-1:0]  symbol;
      logic [BYTE_W-1:0] data;
      logic [CNT_W-1:0]  nbits;
      logic              last;
   } q_entry_type;

endpackage

### design/fluc_front.sv
// ----------------------------------------------------------------------------
// fluc_front: input word classifier
// Strips the stream header, tracks the tail bit count and queues work.
// ----------------------------------------------------------------------------
module fluc_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_type,
   input  logic [fluc_pkg::IDX_W-1:0]    req_dict_index,
   input  logic [fluc_pkg::SYM_W-1:0]    req_dict_symbol,
   input  logic [fluc_pkg::BYTE_W-1:0]   req_data_byte,
   input  logic                          req_is_last_byte,
   input  logic                          q_full,
   output logic                          q_push,
   output fluc_pkg::q_entry_type         q_entry
);

   logic                         first_ff, first_in;
   logic [fluc_pkg::CNT_W-1:0]   tail_ff, tail_in;
   logic [fluc_pkg::CNT_W-1:0]   tail_now;

   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      // header of the first byte: zero means a full final byte
      if (first_ff) begin
         if (req_data_byte[2:0] == 3'd0) begin
            tail_now = fluc_pkg::BYTE_BITS;
         end else begin
            tail_now = {1'b0, req_data_byte[2:0]};
         end
      end else begin
         tail_now = tail_ff;
      end

      q_entry.is_load = (req_type == fluc_pkg::REQ_LOAD);
      q_entry.index   = req_dict_index;
      q_entry.symbol  = req_dict_symbol;
      q_entry.data    = first_ff ? (req_data_byte & fluc_pkg::HDR_CLEAR) : req_data_byte;
      q_entry.nbits   = req_is_last_byte ? tail_now : fluc_pkg::BYTE_BITS;
      q_entry.last    = req_is_last_byte;

      first_in = first_ff;
      tail_in  = tail_ff;
      if (q_push && (req_type == fluc_pkg::REQ_DATA)) begin
         first_in = req_is_last_byte;
         tail_in  = tail_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= 1'b1;
         tail_ff  <= fluc_pkg::BYTE_BITS;
      end else begin
         first_ff <= first_in;
         tail_ff  <= tail_in;
      end
   end

endmodule

### design/fluc_queue.sv
// ----------------------------------------------------------------------------
// fluc_queue: short work queue
// Two-entry FIFO between the classifier and the decode engine.
// ----------------------------------------------------------------------------
module fluc_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  fluc_pkg::q_entry_type push_entry,
   output logic                  full,
   input  logic                  pop,
   output logic                  valid,
   output fluc_pkg::q_entry_type head
);

   localparam int PTR_W = (fluc_pkg::Q_DEPTH > 1) ? $clog2(fluc_pkg::Q_DEPTH) : 1;
   localparam int CNT_W = $clog2(fluc_pkg::Q_DEPTH + 1);

   fluc_pkg::q_entry_type entry_ff [fluc_pkg::Q_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(fluc_pkg::Q_DEPTH));
   assign valid   = (count_ff != '0);
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] n;
      if (p == PTR_W'(fluc_pkg::Q_DEPTH - 1)) begin
         n = '0;
      end else begin
         n = p + PTR_W'(1);
      end
      return n;
   endfunction

   always_comb begin
      wr_ptr_in = do_push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### design/fluc_back.sv
// ----------------------------------------------------------------------------
// fluc_back: decode engine
// Dictionary memory, bit-serial code gathering, lookup and output register.
// ----------------------------------------------------------------------------
module fluc_back #(
   parameter int DICT_DEPTH    = fluc_pkg::DICT_DEPTH_DEF,
   parameter int MAX_CODE_BITS = fluc_pkg::MAX_CODE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [fluc_pkg::CSR_W-1:0]    csr_wr_data,
   input  logic                          q_valid,
   input  fluc_pkg::q_entry_type         q_head,
   output logic                          q_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [fluc_pkg::SYM_W-1:0]    rsp_symbol,
   output logic                          rsp_last_of_run
);

   localparam int AW = $clog2(DICT_DEPTH);
   localparam int CW = MAX_CODE_BITS;
   localparam int PW = $clog2(MAX_CODE_BITS + 1);
   localparam int WW = 16;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_SHIFT = 2'b10
   } back_state_type;

   back_state_type state_ff, state_in;

   logic [fluc_pkg::CSR_W-1:0]  csr_len_ff;
   logic [PW-1:0]               len;

   logic [fluc_pkg::BYTE_W-1:0] shift_ff, shift_in;
   logic [fluc_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic                        last_ff, last_in;
   logic [CW-1:0]               code_ff, code_in;
   logic [PW-1:0]               pos_ff, pos_in;

   logic [CW-1:0]               code_eff, code_new;
   logic [PW-1:0]               pos_eff, pos_new;
   logic                        done_code, final_bit, sym_last, step_go, slot_free;
   logic [WW-1:0]               code_wide, idx_wide;

   logic                        lk_valid_ff, lk_valid_in;
   logic                        lk_last_ff, lk_oob_ff;
   logic                        lk_move;

   logic [fluc_pkg::SYM_W-1:0]  mem [DICT_DEPTH];
   logic [fluc_pkg::SYM_W-1:0]  mem_rd_ff;
   logic                        mem_we;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [fluc_pkg::SYM_W-1:0]  rsp_symbol_ff;
   logic                        rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_len_ff <= fluc_pkg::CODE_LEN_RESET;
      end else if (csr_wr_en) begin
         csr_len_ff <= csr_wr_data;
      end
   end

   // zero acts as one, oversize clamps to the widest code
   always_comb begin
      if (csr_len_ff == '0) begin
         len = PW'(1);
      end else if (csr_len_ff > fluc_pkg::CSR_W'(MAX_CODE_BITS)) begin
         len = PW'(MAX_CODE_BITS);
      end else begin
         len = PW'(csr_len_ff);
      end
   end

   // one bit step
   always_comb begin
      if (pos_ff >= len) begin
         pos_eff  = '0;
         code_eff = '0;
      end else begin
         pos_eff  = pos_ff;
         code_eff = code_ff;
      end
      code_new  = (code_eff & ~(CW'(1) << pos_eff)) | (CW'(shift_ff[0]) << pos_eff);
      pos_new   = pos_eff + PW'(1);
      done_code = (pos_new == len);
      final_bit = (cnt_ff == fluc_pkg::CNT_W'(1));
      sym_last  = ((cnt_ff - fluc_pkg::CNT_W'(1)) < fluc_pkg::CNT_W'(len));
      code_wide = WW'(code_new);
      idx_wide  = WW'(q_head.index);
   end

   assign lk_move   = lk_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign slot_free = !lk_valid_ff || lk_move;
   assign step_go   = (state_ff == ST_SHIFT) && (!done_code || slot_free);
   assign q_pop     = (state_ff == ST_IDLE) && q_valid;
   assign mem_we    = q_pop && q_head.is_load && (idx_wide < WW'(DICT_DEPTH));

   always_comb begin
      state_in    = state_ff;
      shift_in    = shift_ff;
      cnt_in      = cnt_ff;
      last_in     = last_ff;
      code_in     = code_ff;
      pos_in      = pos_ff;
      lk_valid_in = lk_move ? 1'b0 : lk_valid_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_pop && !q_head.is_load) begin
               shift_in = q_head.data;
               cnt_in   = q_head.nbits;
               last_in  = q_head.last;
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            if (step_go) begin
               shift_in = shift_ff >> 1;
               cnt_in   = cnt_ff - fluc_pkg::CNT_W'(1);
               if (done_code || (final_bit && last_ff)) begin
                  code_in = '0;
                  pos_in  = '0;
               end else begin
                  code_in = code_new;
                  pos_in  = pos_new;
               end
               if (done_code) begin
                  lk_valid_in = 1'b1;
               end
               if (final_bit) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         cnt_ff      <= '0;
         last_ff     <= 1'b0;
         code_ff     <= '0;
         pos_ff      <= '0;
         lk_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         last_ff     <= last_in;
         code_ff     <= code_in;
         pos_ff      <= pos_in;
         lk_valid_ff <= lk_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      if (step_go && done_code) begin
         lk_last_ff <= sym_last;
         lk_oob_ff  <= (code_wide >= WW'(DICT_DEPTH));
      end
   end

   // dictionary: one write port for loads, one registered read for lookups
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[idx_wide[AW-1:0]] <= q_head.symbol;
      end
      if (step_go && done_code) begin
         mem_rd_ff <= mem[code_wide[AW-1:0]];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (lk_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (lk_move) begin
         rsp_symbol_ff <= lk_oob_ff ? '0 : mem_rd_ff;
         rsp_last_ff   <= lk_last_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_symbol      = rsp_symbol_ff;
   assign rsp_last_of_run = rsp_last_ff;

endmodule

### design/fixed_length_code_unpacker_top.sv
// ----------------------------------------------------------------------------
// fixed_length_code_unpacker_top: fixed-length dictionary code unpacker
// Loads a symbol dictionary and decodes a packed stream of fixed-length codes.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : input words, valid/ready. req_type selects a dictionary load
//            (req_dict_index, req_dict_symbol) or one compressed byte
//            (req_data_byte, req_is_last_byte).
//   rsp_*  : one decoded symbol per word, valid/ready; rsp_last_of_run marks
//            the final symbol produced by one input byte.
//   csr_*  : code_length write, taken in the cycle csr_wr_en is high. Write it
//            only while the block is idle.
// Stream: the low three bits of a stream's first byte give the valid bit count
//   of its last byte (zero means eight); they are decoded as zero code bits.
// Throughput: the engine takes a load while idle and stays idle. A data byte
//   is dispatched, then the gather loop in fluc_back shifts one code bit per
//   cycle unless backpressure holds it; the next word waits for the last bit.
// Path: a symbol passes the queue, dispatch, gather loop, registered
//   dictionary lookup stage and output register.
// Backpressure: a two-word queue decouples the classifier from the engine and
//   a lookup stage plus output register decouple the engine from rsp_ready;
//   a stalled receiver holds the gather loop at a completed code once both are full.
// Reset: synchronous, active high. Queue and outputs empty, code_length = 8,
//   next byte is taken as a stream's first. Dictionary content is undefined.
// ----------------------------------------------------------------------------
module fixed_length_code_unpacker_top #(
   parameter int DICT_DEPTH    = fluc_pkg::DICT_DEPTH_DEF,
   parameter int MAX_CODE_BITS = fluc_pkg::MAX_CODE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_type,
   input  logic [fluc_pkg::IDX_W-1:0]    req_dict_index,
   input  logic [fluc_pkg::SYM_W-1:0]    req_dict_symbol,
   input  logic [fluc_pkg::BYTE_W-1:0]   req_data_byte,
   input  logic                          req_is_last_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [fluc_pkg::SYM_W-1:0]    rsp_symbol,
   output logic                          rsp_last_of_run,
   input  logic                          csr_wr_en,
   input  logic [fluc_pkg::CSR_W-1:0]    csr_wr_data
);

   // front -> queue
   logic                  q_full;
   logic                  q_push;
   fluc_pkg::q_entry_type q_entry;
   // queue -> back
   logic                  q_valid;
   logic                  q_pop;
   fluc_pkg::q_entry_type q_head;

   fluc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_dict_index   (req_dict_index),
      .req_dict_symbol  (req_dict_symbol),
      .req_data_byte    (req_data_byte),
      .req_is_last_byte (req_is_last_byte),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_entry          (q_entry)
   );

   fluc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .valid      (q_valid),
      .head       (q_head)
   );

   fluc_back #(
      .DICT_DEPTH    (DICT_DEPTH),
      .MAX_CODE_BITS (MAX_CODE_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .q_valid         (q_valid),
      .q_head          (q_head),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_symbol      (rsp_symbol),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

### design/fluc_checker.sv
// ----------------------------------------------------------------------------
// fluc_checker: port-level checks of the code unpacker
// Output hold under stall and reset behavior seen at the ports.
// ----------------------------------------------------------------------------
module fluc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [fluc_pkg::SYM_W-1:0]    rsp_symbol,
   input logic                          rsp_last_of_run
);

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_symbol)
                                 && $stable(rsp_last_of_run))
      else $error("rsp word changed while stalled");

   // no word can reach the output right after reset: queue, engine, lookup and output register lie between
   a_rsp_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid ##1 !rsp_valid ##1 !rsp_valid)
      else $error("rsp_valid too soon after reset");

   // queue is empty after reset
   a_req_ready: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("req_ready low after reset");

endmodule

bind fixed_length_code_unpacker_top fluc_checker u_fluc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_symbol      (rsp_symbol),
   .rsp_last_of_run (rsp_last_of_run)
);

### verif/tb_fixed_length_code_unpacker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fixed_length_code_unpacker_top: self-checking bench for the code unpacker
// Preloads the dictionary, then runs directed streams and random streams at
// many code lengths. A scoreboard predicts every decoded symbol and checks the
// response words in order, while both sides idle and stall at random.
// ----------------------------------------------------------------------------

typedef struct packed {
   logic [fluc_pkg::SYM_W-1:0] symbol;
   logic                       last;
} decoded_sym_type;

class symbol_scoreboard;
   logic [fluc_pkg::SYM_W-1:0] dict_mem [fluc_pkg::DICT_DEPTH_DEF];
   logic [fluc_pkg::CSR_W-1:0] code_length;
   logic [fluc_pkg::SYM_W-1:0] code_acc;
   int unsigned                gathered;
   bit                         header_next;
   int unsigned                tail_bits;
   decoded_sym_type            expected_q [$];
   int unsigned                mismatches;

   function new();
      code_length = fluc_pkg::CODE_LEN_RESET;
      code_acc    = '0;
      gathered    = 0;
      header_next = 1'b1;
      tail_bits   = 32'(fluc_pkg::BYTE_BITS);
      mismatches  = 0;
   endfunction

   function void set_code_length(logic [fluc_pkg::CSR_W-1:0] value);
      code_length = value;
   endfunction

   function int unsigned pending();
      return expected_q.size();
   endfunction

   // Runs one accepted input word through the decoder state.
   function void note_word(logic kind, logic [fluc_pkg::IDX_W-1:0] idx,
                           logic [fluc_pkg::SYM_W-1:0] sym,
                           logic [fluc_pkg::BYTE_W-1:0] data, logic last);
      int unsigned                 len;
      int unsigned                 nbits;
      int unsigned                 done;
      int unsigned                 i;
      logic [fluc_pkg::BYTE_W-1:0] bits;
      logic [fluc_pkg::SYM_W-1:0]  mask;
      logic [fluc_pkg::SYM_W-1:0]  held;
      decoded_sym_type             d;
      if (kind == fluc_pkg::REQ_LOAD) begin
         dict_mem[idx] = sym;
         return;
      end
      if (code_length == 0)
         len = 1;
      else if (code_length > fluc_pkg::MAX_CODE_BITS_DEF)
         len = fluc_pkg::MAX_CODE_BITS_DEF;
      else
         len = 32'(code_length);
      mask = (len >= fluc_pkg::SYM_W) ? {fluc_pkg::SYM_W{1'b1}}
                                      : fluc_pkg::SYM_W'((1 << len) - 1);
      bits = data;
      if (header_next) begin
         tail_bits = 32'(data[2:0]);
         if (tail_bits == 0)
            tail_bits = 32'(fluc_pkg::BYTE_BITS);
         bits        = data & fluc_pkg::HDR_CLEAR;
         header_next = 1'b0;
      end
      nbits = last ? tail_bits : 32'(fluc_pkg::BYTE_BITS);
      done  = 0;
      held  = '0;
      for (i = 0; i < nbits; i++) begin
         if (gathered >= len) begin
            gathered = 0;
            code_acc = '0;
         end
         code_acc[gathered] = bits[i];
         gathered++;
         if (gathered == len) begin
            // push the previous code now; only the final one gets the flag
            if (done > 0) begin
               d.symbol = held;
               d.last   = 1'b0;
               expected_q.push_back(d);
            end
            held = dict_mem[code_acc & mask];
            done++;
            gathered = 0;
            code_acc = '0;
         end
      end
      if (done > 0) begin
         d.symbol = held;
         d.last   = 1'b1;
         expected_q.push_back(d);
      end
      if (last) begin
         header_next = 1'b1;
         gathered    = 0;
         code_acc    = '0;
      end
   endfunction

   function void check_symbol(logic [fluc_pkg::SYM_W-1:0] sym, logic last);
      decoded_sym_type want;
      if (expected_q.size() == 0) begin
         $error("unexpected response word: symbol=%0h last_of_run=%0b", sym, last);
         mismatches++;
         return;
      end
      want = expected_q.pop_front();
      if (sym !== want.symbol) begin
         $error("symbol: expected %0h, actual %0h", want.symbol, sym);
         mismatches++;
      end
      if (last !== want.last) begin
         $error("last_of_run: expected %0b, actual %0b", want.last, last);
         mismatches++;
      end
   endfunction
endclass

module tb_fixed_length_code_unpacker_top;

   localparam int QUIET_CYCLES   = 40;    // > two queued bytes plus lookup and output
   localparam int HOLD_CYCLES    = 150;   // long receiver stall, fills the pipe
   localparam int WATCHDOG_LIMIT = 2000;  // cycles without any handshake
   localparam int PHASES         = 12;
   localparam int PHASE_WORDS    = 1;
   localparam int HOLD_WORDS     = 10;    // enough words to back up to req_ready

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   logic                          req_type;
   logic [fluc_pkg::IDX_W-1:0]    req_dict_index;
   logic [fluc_pkg::SYM_W-1:0]    req_dict_symbol;
   logic [fluc_pkg::BYTE_W-1:0]   req_data_byte;
   logic                          req_is_last_byte;
   logic                          rsp_valid;
   logic                          rsp_ready;
   logic [fluc_pkg::SYM_W-1:0]    rsp_symbol;
   logic                          rsp_last_of_run;
   logic                          csr_wr_en;
   logic [fluc_pkg::CSR_W-1:0]    csr_wr_data;

   symbol_scoreboard    board;

   // idle percentages, changed by the stimulus between phases
   int unsigned         send_idle_pct;
   int unsigned         recv_idle_pct;
   // hold-off handshake between stimulus and receiver processes
   int unsigned         hold_requests;

   fixed_length_code_unpacker_top u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_dict_index   (req_dict_index),
      .req_dict_symbol  (req_dict_symbol),
      .req_data_byte    (req_data_byte),
      .req_is_last_byte (req_is_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_symbol       (rsp_symbol),
      .rsp_last_of_run  (rsp_last_of_run),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   // 4 ns clock
   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Monitor: everything is sampled at the rising edge, so the values seen are
   // the ones the block saw. Input words feed the predictor, response words
   // are checked against the oldest prediction.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            board.note_word(req_type, req_dict_index, req_dict_symbol,
                            req_data_byte, req_is_last_byte);
         if (rsp_valid && rsp_ready)
            board.check_symbol(rsp_symbol, rsp_last_of_run);
      end
   end

   // ------------------------------------------------------------------------
   // Receiver: random ready per cycle. A hold-off request drops ready for a
   // fixed count of cycles, counted here, so the sender keeps pushing words
   // until the block backs up to req_ready.
   // ------------------------------------------------------------------------
   initial begin : receiver
      int unsigned hold_left;
      int unsigned hold_served;
      hold_left   = 0;
      hold_served = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog: a long run of cycles with no handshake on either side means
   // the block is stuck.
   // ------------------------------------------------------------------------
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Offers one word and returns in the step of the edge that took it. Valid
   // stays high on return; the next call or a drain decides whether it drops.
   task automatic send_word(input logic kind, input logic [fluc_pkg::IDX_W-1:0] idx,
                            input logic [fluc_pkg::SYM_W-1:0] sym,
                            input logic [fluc_pkg::BYTE_W-1:0] data,
                            input logic last);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_type         <= kind;
      req_dict_index   <= idx;
      req_dict_symbol  <= sym;
      req_data_byte    <= data;
      req_is_last_byte <= last;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   // data word; dictionary fields are don't-care and get random values
   task automatic send_data(input logic [fluc_pkg::BYTE_W-1:0] data, input logic last);
      send_word(fluc_pkg::REQ_DATA, fluc_pkg::IDX_W'($urandom_range(0, 255)),
                fluc_pkg::SYM_W'($urandom_range(0, 255)), data, last);
   endtask

   // Drop valid, wait for every predicted symbol, then let any word that
   // produces nothing (load, partial code) finish inside the engine.
   task automatic wait_drained;
      req_valid <= 1'b0;
      while (board.pending() != 0)
         @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   // code_length only changes while the block is idle
   task automatic write_code_length(input logic [fluc_pkg::CSR_W-1:0] value);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      board.set_code_length(value);
   endtask

   // One stream of 1..3 bytes with random content and random header. Some
   // streams are left open (no last byte) so partial codes and a pending
   // tail cross into the next phase; loads are sprinkled in as noise.
   task automatic send_random_stream(inout int unsigned sent);
      int unsigned n_bytes;
      int unsigned k;
      bit          left_open;
      n_bytes   = $urandom_range(1, 3);
      left_open = ($urandom_range(0, 99) < 12);
      for (k = 0; k < n_bytes; k++) begin
         if ($urandom_range(0, 99) < 15) begin
            send_word(fluc_pkg::REQ_LOAD, fluc_pkg::IDX_W'($urandom_range(0, 255)),
                      fluc_pkg::SYM_W'($urandom_range(0, 255)),
                      fluc_pkg::BYTE_W'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
            sent++;
         end
         send_data(fluc_pkg::BYTE_W'($urandom_range(0, 255)),
                   (k == n_bytes - 1) && !left_open);
         sent++;
      end
   endtask

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin : stimulus
      int unsigned phase;
      int unsigned sent;
      int unsigned want;
      int unsigned i;
      board         = new();
      send_idle_pct = 33;
      recv_idle_pct = 83;
      hold_requests = 0;

      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_type         <= fluc_pkg::REQ_LOAD;
      req_dict_index   <= '0;
      req_dict_symbol  <= '0;
      req_data_byte    <= '0;
      req_is_last_byte <= 1'b0;
      csr_wr_en        <= 1'b0;
      csr_wr_data      <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Fill the whole dictionary first: every code the stream can form is
      // then backed by a written entry.
      for (i = 0; i < fluc_pkg::DICT_DEPTH_DEF; i++)
         send_word(fluc_pkg::REQ_LOAD, fluc_pkg::IDX_W'(i),
                   fluc_pkg::SYM_W'($urandom_range(0, 255)),
                   fluc_pkg::BYTE_W'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)));

      // ---- directed part, code length still at its reset value of eight ----
      send_data(8'hF8, 1'b1);   // first and last at once, header 0: eight bits
      send_data(8'h07, 1'b1);   // first and last, seven bits: no full code
      send_data(8'h05, 1'b0);   // header 5 -> last byte carries five bits
      send_data(8'hFF, 1'b0);
      // loads in mid stream, data fields ignored
      send_word(fluc_pkg::REQ_LOAD, 8'h00, 8'hFF, 8'hFF, 1'b1);
      send_word(fluc_pkg::REQ_LOAD, 8'hFF, 8'h00, 8'h00, 1'b0);
      send_data(8'h00, 1'b1);   // five bits only, partial code dropped at end

      write_code_length(4'd1);  // one bit per code: eight symbols per byte
      send_data(8'hAA, 1'b0);
      send_data(8'h55, 1'b1);

      write_code_length(4'd0);  // zero acts as one
      send_data(8'h01, 1'b0);
      send_data(8'hFF, 1'b1);

      write_code_length(4'hF);  // above the maximum acts as eight
      send_data(8'h00, 1'b0);
      send_data(8'hFF, 1'b0);
      send_data(8'h80, 1'b1);

      // shorten the code while bits are held, beyond and within the new length
      write_code_length(4'd5);
      send_data(8'hE8, 1'b0);   // one code, three bits held
      write_code_length(4'd2);  // three held bits >= 2: thrown away
      send_data(8'h3C, 1'b0);
      write_code_length(4'd7);
      send_data(8'h96, 1'b0);   // one code, one bit held
      write_code_length(4'd4);  // one held bit < 4: kept
      send_data(8'h5A, 1'b1);

      // ---- random part ----
      // Stride 5 mod 16 walks 3, 8, 13, 2, 7, 12, 1, 6, 11, 0, 5, 10: both
      // ends of the legal range plus the clamped values on either side.
      for (phase = 0; phase < PHASES; phase++) begin
         write_code_length(fluc_pkg::CSR_W'((phase * 5 + 3) % 16));
         if (phase < PHASES / 3) begin
            send_idle_pct = 33;
            recv_idle_pct = 83;
         end else if (phase < 2 * PHASES / 3) begin
            send_idle_pct = 83;
            recv_idle_pct = 33;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         // full-rate sender against a stalled receiver: back pressure
         want = PHASE_WORDS;
         if (phase == 2 * PHASES / 3) begin
            hold_requests++;
            want = HOLD_WORDS;
         end
         sent = 0;
         while (sent < want)
            send_random_stream(sent);
      end

      wait_drained();
      if (board.pending() != 0)
         $error("%0d predicted symbols never arrived", board.pending());
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

### sim.f
design/fluc_pkg.sv
design/fluc_front.sv
design/fluc_queue.sv
design/fluc_back.sv
design/fixed_length_code_unpacker_top.sv
design/fluc_checker.sv
verif/tb_fixed_length_code_unpacker_top.sv
